### rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ============================================================================
package u8d_pkg;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE   = 3'd1;
    localparam logic [2:0] ST_OVERLONG     = 3'd2;
    localparam logic [2:0] ST_INVALID_SEQ  = 3'd3;
    localparam logic [2:0] ST_INVALID_UNIT = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_stream;
    } byte_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  status;
        logic [2:0]  consumed_bytes;
        logic [2:0]  expected_bytes;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

### rtl/u8d_front.sv
`timescale 1ns / 1ps
// ============================================================================
// u8d_front
// Byte intake: tracks the open sequence and classifies up to two results.
// ============================================================================
module u8d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  u8d_pkg::byte_t    data,
    output u8d_pkg::push_t    push
);
    import u8d_pkg::*;

    logic [2:0]  pend_reg, pend_next;
    logic [2:0]  tlen_reg, tlen_next;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  sec_reg, sec_next;
    logic [20:0] acc_reg, acc_next;

    logic [7:0]  b;
    logic        eos;
    logic        cont;
    logic [2:0]  pend_inc;
    logic [7:0]  sec_inc;
    logic [20:0] acc_inc;
    logic [2:0]  fin_st;
    result_t     flush_res;

    logic        s_emit;
    logic        s_open;
    logic [2:0]  s_tlen;
    logic [20:0] s_acc;
    result_t     s_res;

    result_t     r0, r1;
    logic [1:0]  n;

    function automatic logic [2:0] finish_status(input logic [7:0] lead,
                                                 input logic [7:0] sec,
                                                 input logic [2:0] tlen);
        logic [2:0] st;
        st = ST_OK;
        if (lead >= 8'hf5)
            st = ST_INVALID_SEQ;
        else if (tlen == 3'd2)
        begin
            if (lead < 8'hc2)
                st = ST_OVERLONG;
        end
        else if (tlen == 3'd3)
        begin
            if (lead == 8'he0 && sec < 8'ha0)
                st = ST_OVERLONG;
            else if (lead == 8'hed && sec >= 8'ha0)
                st = ST_INVALID_SEQ;
        end
        else
        begin
            if (lead == 8'hf0 && sec < 8'h90)
                st = ST_OVERLONG;
            else if (lead == 8'hf4 && sec >= 8'h90)
                st = ST_INVALID_SEQ;
        end
        return st;
    endfunction

    function automatic result_t short_result(input logic [7:0] lead,
                                             input logic [2:0] cnt,
                                             input logic [2:0] tlen);
        result_t r;
        r = '0;
        r.consumed_bytes = cnt;
        if (lead >= 8'hf5)
            r.status = ST_INVALID_SEQ;
        else
        begin
            r.status         = ST_INCOMPLETE;
            r.expected_bytes = tlen;
        end
        return r;
    endfunction

    assign b        = data.byte_in;
    assign eos      = data.end_of_stream;
    assign cont     = (b[7:6] == 2'b10);
    assign pend_inc = pend_reg + 3'd1;
    assign sec_inc  = (pend_reg == 3'd1) ? b : sec_reg;
    assign acc_inc  = {acc_reg[14:0], b[5:0]};
    assign fin_st   = finish_status(lead_reg, sec_inc, tlen_reg);
    assign flush_res = short_result(lead_reg, cont ? pend_inc : pend_reg, tlen_reg);

    // classify a byte seen with no sequence open
    always_comb
    begin
        s_emit = 1'b0;
        s_open = 1'b0;
        s_res  = '0;
        s_tlen = 3'd0;
        s_acc  = '0;
        if (b < 8'hc0)
        begin
            s_tlen = 3'd0;
        end
        else if (b < 8'he0)
        begin
            s_tlen = 3'd2;
            s_acc  = {16'd0, b[4:0]};
        end
        else if (b < 8'hf0)
        begin
            s_tlen = 3'd3;
            s_acc  = {17'd0, b[3:0]};
        end
        else if (b < 8'hf8)
        begin
            s_tlen = 3'd4;
            s_acc  = {18'd0, b[2:0]};
        end
        else if (b < 8'hfc)
            s_tlen = 3'd5;
        else
            s_tlen = 3'd6;

        if (b < 8'h80)
        begin
            s_emit               = 1'b1;
            s_res.code_point     = {13'd0, b};
            s_res.status         = ST_OK;
            s_res.consumed_bytes = 3'd1;
        end
        else if (b < 8'hc0 || b >= 8'hfe)
        begin
            s_emit               = 1'b1;
            s_res.status         = ST_INVALID_UNIT;
            s_res.consumed_bytes = 3'd1;
        end
        else if (eos)
        begin
            s_emit = 1'b1;
            s_res  = short_result(b, 3'd1, s_tlen);
        end
        else
            s_open = 1'b1;
    end

    always_comb
    begin
        pend_next = pend_reg;
        tlen_next = tlen_reg;
        lead_next = lead_reg;
        sec_next  = sec_reg;
        acc_next  = acc_reg;
        r0        = '0;
        r1        = '0;
        n         = 2'd0;
        if (pend_reg != 3'd0)
        begin
            if (cont)
            begin
                pend_next = pend_inc;
                sec_next  = sec_inc;
                acc_next  = acc_inc;
                if (pend_inc >= tlen_reg)
                begin
                    r0.code_point     = (fin_st == ST_OK) ? acc_inc : '0;
                    r0.status         = fin_st;
                    r0.consumed_bytes = tlen_reg;
                    n = 2'd1;
                end
                else if (eos)
                begin
                    r0 = flush_res;
                    n  = 2'd1;
                end
                if (n != 2'd0)
                begin
                    pend_next = '0;
                    tlen_next = '0;
                    lead_next = '0;
                    sec_next  = '0;
                    acc_next  = '0;
                end
            end
            else
            begin
                r0 = flush_res;
                r1 = s_res;
                n  = s_emit ? 2'd2 : 2'd1;
                pend_next = s_open ? 3'd1 : 3'd0;
                tlen_next = s_open ? s_tlen : 3'd0;
                lead_next = s_open ? b : 8'd0;
                sec_next  = '0;
                acc_next  = s_open ? s_acc : '0;
            end
        end
        else
        begin
            r0 = s_res;
            n  = s_emit ? 2'd1 : 2'd0;
            if (s_open)
            begin
                pend_next = 3'd1;
                tlen_next = s_tlen;
                lead_next = b;
                sec_next  = '0;
                acc_next  = s_acc;
            end
        end
        r0.last_of_run = (n == 2'd1);
        r1.last_of_run = (n == 2'd2);
    end

    always_comb
    begin
        push.count  = accept ? n : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            tlen_reg <= '0;
            lead_reg <= '0;
            sec_reg  <= '0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            tlen_reg <= tlen_next;
            lead_reg <= lead_next;
            sec_reg  <= sec_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

### rtl/u8d_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// u8d_queue
// Short result queue: up to two pushes and one pop per cycle.
// ============================================================================
module u8d_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  u8d_pkg::push_t          push,
    input  logic                    pop,
    output logic                    not_empty,
    output logic                    full,
    output u8d_pkg::result_t        head
);
    import u8d_pkg::*;

    result_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [QPTR_W-1:0]   wr_plus1;

    assign wr_plus1  = wr_reg + QPTR_W'(1);
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg > QCNT_W'(QDEPTH - 2));
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.count);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/u8d_back.sv
`timescale 1ns / 1ps
// ============================================================================
// u8d_back
// Output stage: drains the queue into a registered result transaction.
// ============================================================================
module u8d_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    not_empty,
    input  u8d_pkg::result_t        head,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output u8d_pkg::result_t        result_data
);
    import u8d_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop          = not_empty && (!valid_reg || !result_stall);
    assign valid_next   = pop || (valid_reg && result_stall);
    assign result_valid = valid_reg;
    assign result_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

### rtl/utf8_stream_decoder_with_error_classes.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_stream_decoder_with_error_classes
// UTF-8 byte stream decoder reporting code points and error classes.
// ============================================================================
// A result passes through a queue entry and then the output register.
// Throughput: one byte per cycle unless byte_stall is set; output drains one
//   result per cycle unless stalled (4-entry queue holds a second result).
// Intake stalls while the queue holds more than two results.
// Reset clears the open sequence, the queue pointers and output valid.
module utf8_stream_decoder_with_error_classes
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_stall,
    input  u8d_pkg::byte_t          byte_data,
    output logic                    result_valid,
    input  logic                    result_stall,
    output u8d_pkg::result_t        result_data
);
    import u8d_pkg::*;

    logic    accept;
    push_t   push;
    logic    pop;
    logic    not_empty;
    logic    full;
    result_t head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    u8d_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (byte_data),
        .push   (push)
    );

    u8d_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (head)
    );

    u8d_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule
